FILE: design/double_sha256_nonce_scan_macros.svh
// Assertion macros shared by the checker.
`ifndef DOUBLE_SHA256_NONCE_SCAN_MACROS_SVH
`define DOUBLE_SHA256_NONCE_SCAN_MACROS_SVH
`define DSN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/dsn_pkg.sv
package dsn_pkg;
    localparam int SCAN_WINDOW_BITS_DEFAULT = 12;

    typedef logic [31:0] word_t;
    typedef logic [255:0] state_t;

    typedef struct packed {
        logic load_hdr;
        logic run_rounds;
        logic init_mid;
        logic init_inner;
        logic init_outer;
        logic save_mid;
        logic finish_block;
        logic bump_nonce;
    } cmd_t;

    typedef struct packed {
        logic last_round;
        logic found;
        logic window_end;
    } stat_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        unique case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    localparam state_t INIT_H = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic word_t bswap(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction
endpackage

FILE: design/dsn_datapath.sv
module dsn_datapath #(
    parameter int SCAN_WINDOW_BITS = dsn_pkg::SCAN_WINDOW_BITS_DEFAULT
) (
    input  logic            clk,
    input  dsn_pkg::cmd_t   cmd,
    output dsn_pkg::stat_t  stat,
    input  logic [31:0]     version_word,
    input  logic [63:0]     prev_hash_w0,
    input  logic [63:0]     prev_hash_w1,
    input  logic [63:0]     prev_hash_w2,
    input  logic [63:0]     prev_hash_w3,
    input  logic [63:0]     root_w0,
    input  logic [63:0]     root_w1,
    input  logic [63:0]     root_w2,
    input  logic [63:0]     root_w3,
    input  logic [31:0]     time_word,
    input  logic [31:0]     bits_word,
    input  logic [31:0]     start_nonce,
    output logic [31:0]     nonce_out,
    output logic [63:0]     hash_w0,
    output logic [63:0]     hash_w1,
    output logic [63:0]     hash_w2,
    output logic [63:0]     hash_w3
);
    localparam int WB = (SCAN_WINDOW_BITS < 1) ? 1 :
                        ((SCAN_WINDOW_BITS > 32) ? 32 : SCAN_WINDOW_BITS);

    logic [511:0]          hdr_reg;
    logic [95:0]           tail_reg;
    logic [31:0]           nonce_reg;
    dsn_pkg::state_t       mid_reg;
    dsn_pkg::state_t       base_reg;
    dsn_pkg::state_t       work_reg;
    dsn_pkg::state_t       dig_reg;
    dsn_pkg::word_t        w_reg [16];
    logic [5:0]            rnd_reg;
    logic [511:0]          blk;
    dsn_pkg::word_t        a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;
    dsn_pkg::state_t       sum;
    logic [31:0]           nonce_next;

    always_comb
    begin
        blk = '0;
        if (cmd.init_mid)
        begin
            blk = hdr_reg;
        end
        else if (cmd.init_inner)
        begin
            blk = {tail_reg, dsn_pkg::bswap(nonce_next), 32'h80000000, 320'h0, 32'd640};
        end
        else
        begin
            blk = {sum, 32'h80000000, 192'h0, 32'd256};
        end
    end

    assign nonce_next = nonce_reg + 32'd1;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = work_reg;
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & f) ^ (~e & g)) + dsn_pkg::round_k(rnd_reg) + w_reg[0];
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & b) ^ (a & c) ^ (b & c));
        for (int i = 0; i < 8; i++)
        begin
            sum[255 - 32*i -: 32] = base_reg[255 - 32*i -: 32] + work_reg[255 - 32*i -: 32];
        end
    end

    always_comb
    begin
        stat.last_round = (rnd_reg == 6'd63);
        stat.found = (sum[15:0] == 16'h0);
        stat.window_end = (nonce_reg[WB-1:0] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_hdr)
        begin
            hdr_reg <= {dsn_pkg::bswap(version_word),
                        dsn_pkg::bswap(prev_hash_w0[31:0]), dsn_pkg::bswap(prev_hash_w0[63:32]),
                        dsn_pkg::bswap(prev_hash_w1[31:0]), dsn_pkg::bswap(prev_hash_w1[63:32]),
                        dsn_pkg::bswap(prev_hash_w2[31:0]), dsn_pkg::bswap(prev_hash_w2[63:32]),
                        dsn_pkg::bswap(prev_hash_w3[31:0]), dsn_pkg::bswap(prev_hash_w3[63:32]),
                        dsn_pkg::bswap(root_w0[31:0]), dsn_pkg::bswap(root_w0[63:32]),
                        dsn_pkg::bswap(root_w1[31:0]), dsn_pkg::bswap(root_w1[63:32]),
                        dsn_pkg::bswap(root_w2[31:0]), dsn_pkg::bswap(root_w2[63:32]),
                        dsn_pkg::bswap(root_w3[31:0])};
            tail_reg <= {dsn_pkg::bswap(root_w3[63:32]), dsn_pkg::bswap(time_word),
                         dsn_pkg::bswap(bits_word)};
            nonce_reg <= start_nonce;
        end
        if (cmd.bump_nonce)
        begin
            nonce_reg <= nonce_next;
        end
        if (cmd.init_mid || cmd.init_inner || cmd.init_outer)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk[511 - 32*i -: 32];
            end
            rnd_reg <= 6'd0;
            if (cmd.init_mid)
            begin
                work_reg <= dsn_pkg::INIT_H;
                base_reg <= dsn_pkg::INIT_H;
            end
            else if (cmd.init_inner)
            begin
                work_reg <= mid_reg;
                base_reg <= mid_reg;
            end
            else
            begin
                work_reg <= dsn_pkg::INIT_H;
                base_reg <= dsn_pkg::INIT_H;
            end
        end
        else if (cmd.run_rounds)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wn;
            work_reg <= {t1 + t2, a, b, c, d + t1, e, f, g};
            rnd_reg <= rnd_reg + 6'd1;
        end
        if (cmd.save_mid)
        begin
            mid_reg <= sum;
        end
        if (cmd.finish_block)
        begin
            dig_reg <= sum;
        end
    end

    always_comb
    begin
        nonce_out = nonce_reg;
        hash_w0 = {dsn_pkg::bswap(dig_reg[223:192]), dsn_pkg::bswap(dig_reg[255:224])};
        hash_w1 = {dsn_pkg::bswap(dig_reg[159:128]), dsn_pkg::bswap(dig_reg[191:160])};
        hash_w2 = {dsn_pkg::bswap(dig_reg[95:64]), dsn_pkg::bswap(dig_reg[127:96])};
        hash_w3 = {dsn_pkg::bswap(dig_reg[31:0]), dsn_pkg::bswap(dig_reg[63:32])};
    end
endmodule

FILE: design/dsn_ctrl.sv
module dsn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output logic           status,
    output dsn_pkg::cmd_t  cmd,
    input  dsn_pkg::stat_t stat
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MID   = 3'd1;
    localparam logic [2:0] S_IN    = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       loaded_reg, loaded_next;
    logic       status_reg, status_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        loaded_next = loaded_reg;
        status_next = status_reg;
        done_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_hdr = 1'b1;
                    state_next = S_MID;
                    loaded_next = 1'b0;
                end
            end
            S_MID:
            begin
                if (!loaded_reg)
                begin
                    cmd.init_mid = 1'b1;
                    loaded_next = 1'b1;
                end
                else
                begin
                    cmd.run_rounds = 1'b1;
                    if (stat.last_round)
                    begin
                        state_next = S_CHECK;
                        loaded_next = 1'b0;
                    end
                end
            end
            S_CHECK:
            begin
                if (!loaded_reg)
                begin
                    cmd.save_mid = 1'b1;
                    loaded_next = 1'b1;
                end
                else
                begin
                    cmd.init_inner = 1'b1;
                    cmd.bump_nonce = 1'b1;
                    state_next = S_IN;
                end
            end
            S_IN:
            begin
                cmd.run_rounds = 1'b1;
                if (stat.last_round)
                begin
                    loaded_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!loaded_reg)
                begin
                    cmd.init_outer = 1'b1;
                    loaded_next = 1'b1;
                end
                else
                begin
                    cmd.run_rounds = 1'b1;
                    if (stat.last_round)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                cmd.finish_block = 1'b1;
                if (stat.found)
                begin
                    status_next = 1'b1;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.window_end)
                begin
                    status_next = 1'b0;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loaded_reg <= 1'b0;
            status_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            loaded_reg <= loaded_next;
            status_reg <= status_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
endmodule

FILE: design/double_sha256_nonce_scan.sv
// Double SHA-256 nonce scanner.
// Raise start while busy is low; all header fields and start_nonce are sampled at
// the edge where start is high and busy is low.
// The block hashes the first 64 header bytes once, then for each nonce
// (start_nonce plus one, wrapping) runs two compressions of 64 rounds each
// on a single round unit, one round per cycle.
// A scan stops when digest bytes 30 and 31 are zero or when the low window bits
// of the nonce are all zero, so at most 2^SCAN_WINDOW_BITS nonces are tried (width clamped to 1..32).
// done is high for one cycle with status, nonce_out and hash_w0..hash_w3 valid;
// the receiver cannot stall and must take it.
// busy is high from the accepting edge until the cycle in which done is shown,
// so a new item can be accepted at the edge that takes the result.
// Reset returns the controller to idle; no result is pending after reset.
module double_sha256_nonce_scan #(
    parameter int SCAN_WINDOW_BITS = dsn_pkg::SCAN_WINDOW_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [31:0] version_word,
    input  logic [63:0] prev_hash_w0,
    input  logic [63:0] prev_hash_w1,
    input  logic [63:0] prev_hash_w2,
    input  logic [63:0] prev_hash_w3,
    input  logic [63:0] root_w0,
    input  logic [63:0] root_w1,
    input  logic [63:0] root_w2,
    input  logic [63:0] root_w3,
    input  logic [31:0] time_word,
    input  logic [31:0] bits_word,
    input  logic [31:0] start_nonce,
    output logic        status,
    output logic [31:0] nonce_out,
    output logic [63:0] hash_w0,
    output logic [63:0] hash_w1,
    output logic [63:0] hash_w2,
    output logic [63:0] hash_w3
);
    dsn_pkg::cmd_t  cmd;
    dsn_pkg::stat_t stat;

    dsn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .status(status), .cmd(cmd), .stat(stat)
    );

    dsn_datapath #(.SCAN_WINDOW_BITS(SCAN_WINDOW_BITS)) u_dp (
        .clk(clk), .cmd(cmd), .stat(stat),
        .version_word(version_word), .prev_hash_w0(prev_hash_w0),
        .prev_hash_w1(prev_hash_w1), .prev_hash_w2(prev_hash_w2),
        .prev_hash_w3(prev_hash_w3), .root_w0(root_w0), .root_w1(root_w1),
        .root_w2(root_w2), .root_w3(root_w3), .time_word(time_word),
        .bits_word(bits_word), .start_nonce(start_nonce), .nonce_out(nonce_out),
        .hash_w0(hash_w0), .hash_w1(hash_w1), .hash_w2(hash_w2), .hash_w3(hash_w3)
    );
endmodule

FILE: design/dsn_checker.sv
`include "double_sha256_nonce_scan_macros.svh"
module dsn_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    `DSN_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `DSN_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `DSN_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

bind double_sha256_nonce_scan dsn_checker u_dsn_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done)
);
